>>> sv/pt64_pkg.sv
// Shared types and constants of the 64-bit primality tester.
// Used by the channel interfaces, the modular multiplier and the top level.
package pt64_pkg;

  // Default sizes of the divisor and exception tables
  localparam int PRIME_DEPTH_DEF  = 1024;
  localparam int EXC_DEPTH_DEF    = 1024;
  localparam int EARLY_PRIMES_DEF = 100;

  localparam int WORD_W  = 64;
  localparam int PRIME_W = 32;
  localparam int COUNT_W = 11;
  localparam int SLOT_W  = 10;
  localparam int CAUSE_W = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TEST      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_PRIME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_EXC  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WITNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXC_CNT   = 2'd2;

  // Verdict causes
  localparam logic [CAUSE_W-1:0] CAUSE_LOAD      = 4'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_TRIVIAL   = 4'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SMALL     = 4'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_SQUARE    = 4'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_DIVISOR   = 4'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_BOUND     = 4'd5;
  localparam logic [CAUSE_W-1:0] CAUSE_EULER     = 4'd6;
  localparam logic [CAUSE_W-1:0] CAUSE_EXCEPTION = 4'd7;
  localparam logic [CAUSE_W-1:0] CAUSE_PASSED    = 4'd8;

  // Request to and response from the modular multiplier
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] n;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } mm_rsp_t;

endpackage

>>> sv/pt64_in_if.sv
// Input channel of the primality tester: valid/ready plus one item.
// Depends on pt64_pkg for field widths.
interface pt64_in_if import pt64_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   table_slot;
  logic [WORD_W-1:0]   operand_word;
  logic [WORD_W-1:0]   inverse_word;
  logic [WORD_W-1:0]   quotient_word;

  modport source (output valid, mode, table_slot, operand_word, inverse_word,
                  quotient_word, input ready);
  modport sink (input valid, mode, table_slot, operand_word, inverse_word,
                quotient_word, output ready);
endinterface

>>> sv/pt64_out_if.sv
// Output channel of the primality tester: valid/ready plus one verdict.
// Depends on pt64_pkg for field widths.
interface pt64_out_if import pt64_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_prime;
  logic [CAUSE_W-1:0] verdict_cause;

  modport source (output valid, is_prime, verdict_cause, input ready);
  modport sink (input valid, is_prime, verdict_cause, output ready);
endinterface

>>> sv/pt64_modmul.sv
// Bit-serial modular multiplier: a*b mod n by double-and-add, one
// modular addition per cycle. Depends on pt64_pkg.
module pt64_modmul import pt64_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic              busy;
  logic              phase;
  logic [5:0]        k;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] n;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] addend;
  logic [WORD_W-1:0] gap;
  logic [WORD_W-1:0] sum;
  logic              done;

  // One modular addition: r + addend mod n, both below n
  always_comb begin
    addend = phase ? a : r;
    gap    = n - addend;
    sum    = (r >= gap) ? (r - gap) : (r + addend);
  end

  // Double on phase 0, conditionally add a on phase 1
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        k     <= '0;
        a     <= req.a;
        b     <= req.b;
        n     <= req.n;
        r     <= '0;
      end else if (busy) begin
        if (!phase) begin
          r     <= sum;
          phase <= 1'b1;
        end else begin
          if (b[WORD_W-1]) begin
            r <= sum;
          end
          b     <= {b[WORD_W-2:0], 1'b0};
          phase <= 1'b0;
          k     <= k + 6'd1;
          if (k == 6'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = r;

endmodule

>>> sv/primality_test_64bit.sv
// Primality tester for 64-bit candidates: top level with sequencer and tables.
// Depends on pt64_pkg, pt64_in_if, pt64_out_if and pt64_modmul.
//
// Usage: items arrive on in_ch. Mode load-prime writes a divisor table entry
// (prime, inverse mod 2^64, floor((2^64-1)/p)); mode load-exception writes one
// entry of the ascending exception list. Mode test checks operand_word.
// Every item gives one verdict on out_ch: is_prime and verdict_cause.
// Configuration (witness base, prime count, exception count) is written on
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this. A load goes straight to
// its verdict. A test takes a square root, checks for a square, divides by
// the early divisors, reduces the witness, raises it to the power (n-1)/2
// on the bit-serial modular multiplier, divides by the remaining divisors,
// checks the ends of the exception list and bisects it. One item is worked
// on at a time; in_ch.ready is high only between items.
// The verdict sits in an output register; a stalled receiver holds it, and
// the block already takes the next item, stalling only at its own verdict.
// Reset clears control state and sets witness 2, prime count 0, exception
// count 1; table contents are undefined until loaded.
module primality_test_64bit import pt64_pkg::*; #(
  parameter int PRIME_DEPTH  = PRIME_DEPTH_DEF,
  parameter int EXC_DEPTH    = EXC_DEPTH_DEF,
  parameter int EARLY_PRIMES = EARLY_PRIMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  pt64_in_if.sink              in_ch,
  pt64_out_if.source           out_ch
);

  localparam int PA = (PRIME_DEPTH > 1) ? $clog2(PRIME_DEPTH) : 1;
  localparam int EA = (EXC_DEPTH > 1) ? $clog2(EXC_DEPTH) : 1;
  localparam int IW = $clog2(PRIME_DEPTH + 1);
  localparam int EW = $clog2(EXC_DEPTH + 1);
  localparam int PE_W = PRIME_W + 2 * WORD_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQRT   = 5'd1;
  localparam logic [4:0] S_SQCHK  = 5'd2;
  localparam logic [4:0] S_TD_RD  = 5'd3;
  localparam logic [4:0] S_TD_M0  = 5'd4;
  localparam logic [4:0] S_TD_M1  = 5'd5;
  localparam logic [4:0] S_TD_M2  = 5'd6;
  localparam logic [4:0] S_TD_CMP = 5'd7;
  localparam logic [4:0] S_DIV    = 5'd8;
  localparam logic [4:0] S_PW     = 5'd9;
  localparam logic [4:0] S_PW_MR  = 5'd10;
  localparam logic [4:0] S_PW_MB  = 5'd11;
  localparam logic [4:0] S_PW_CHK = 5'd12;
  localparam logic [4:0] S_EX_R0  = 5'd13;
  localparam logic [4:0] S_EX_RH  = 5'd14;
  localparam logic [4:0] S_EX_C1  = 5'd15;
  localparam logic [4:0] S_EX_RM  = 5'd16;
  localparam logic [4:0] S_EX_CM  = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  // Configuration registers
  logic [WORD_W-1:0]  witness_base;
  logic [COUNT_W-1:0] prime_count;
  logic [COUNT_W-1:0] exception_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      witness_base    <= WORD_W'(2);
      prime_count     <= '0;
      exception_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WITNESS:   witness_base    <= cfg_wdata;
        CFG_PRIME_CNT: prime_count     <= cfg_wdata[COUNT_W-1:0];
        CFG_EXC_CNT:   exception_count <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated counts
  logic [IW-1:0] pc_eff;
  logic [IW-1:0] early_eff;
  logic [EW-1:0] ec_eff;

  always_comb begin
    pc_eff = (32'(prime_count) >= 32'(PRIME_DEPTH)) ? IW'(PRIME_DEPTH) : IW'(prime_count);
    early_eff = (32'(pc_eff) >= 32'(EARLY_PRIMES)) ? IW'(EARLY_PRIMES) : pc_eff;
    ec_eff = (32'(exception_count) >= 32'(EXC_DEPTH)) ? EW'(EXC_DEPTH)
                                                      : EW'(exception_count);
  end

  // Sequencer registers
  logic [4:0]        state;
  logic [4:0]        state_next;
  logic [CAUSE_W-1:0] cause;
  logic [WORD_W-1:0] n;
  logic [WORD_W-1:0] sq_rem;
  logic [WORD_W-1:0] sq_root;
  logic [WORD_W-1:0] sq_bit;
  logic [PRIME_W-1:0] pmax;
  logic [IW-1:0]     idx;
  logic              late;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] dv_rem;
  logic [WORD_W-1:0] dv_sh;
  logic [5:0]        k;
  logic [WORD_W-1:0] pw_r;
  logic [WORD_W-1:0] pw_b;
  logic [WORD_W-1:0] pw_e;
  logic [EA-1:0]     ex_lo;
  logic [EA-1:0]     ex_hi;
  logic [EA-1:0]     ex_mid;
  logic              ex_lt0;
  logic              ex_eq0;
  logic              out_valid;
  logic              out_prime;
  logic [CAUSE_W-1:0] out_cause;

  // Tables
  logic [PE_W-1:0]   prime_mem [PRIME_DEPTH];
  logic [WORD_W-1:0] exc_mem [EXC_DEPTH];
  logic [PE_W-1:0]   prime_rd;
  logic [WORD_W-1:0] exc_rd;
  logic [EA-1:0]     exc_raddr;

  logic in_xfer;
  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    case (state)
      S_EX_RH: exc_raddr = ex_hi;
      S_EX_RM: exc_raddr = ex_mid;
      default: exc_raddr = '0;
    endcase
  end

  // Write on load transfers, read every cycle
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.mode == MODE_LOAD_PRIME &&
        32'(in_ch.table_slot) < 32'(PRIME_DEPTH)) begin
      prime_mem[PA'(in_ch.table_slot)] <= {in_ch.operand_word[PRIME_W-1:0],
                                           in_ch.inverse_word, in_ch.quotient_word};
    end
    prime_rd <= prime_mem[idx[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.mode == MODE_LOAD_EXC &&
        32'(in_ch.table_slot) < 32'(EXC_DEPTH)) begin
      exc_mem[EA'(in_ch.table_slot)] <= in_ch.operand_word;
    end
    exc_rd <= exc_mem[exc_raddr];
  end

  logic [PRIME_W-1:0] rd_prime;
  logic [WORD_W-1:0]  rd_inv;
  logic [WORD_W-1:0]  rd_quot;
  assign {rd_prime, rd_inv, rd_quot} = prime_rd;

  // Shared 32x32 multiplier for the low product of inverse * n
  logic [PRIME_W-1:0] mul_a;
  logic [PRIME_W-1:0] mul_b;
  logic [WORD_W-1:0]  prod;

  always_comb begin
    case (state)
      S_TD_M0: begin
        mul_a = rd_inv[31:0];
        mul_b = n[31:0];
      end
      S_TD_M1: begin
        mul_a = rd_inv[31:0];
        mul_b = n[63:32];
      end
      default: begin
        mul_a = rd_inv[63:32];
        mul_b = n[31:0];
      end
    endcase
    prod = WORD_W'(mul_a) * WORD_W'(mul_b);
  end

  // Square root step, witness reduction step and bisection midpoint
  logic [WORD_W-1:0] sq_try;
  logic [WORD_W:0]   dv_try;
  logic [EA:0]       ex_sum;
  logic [EA-1:0]     ex_lo_n;
  logic [EA-1:0]     ex_hi_n;
  logic [EA-1:0]     ex_mid_n;
  logic [IW-1:0]     stop;

  always_comb begin
    sq_try  = sq_root + sq_bit;
    dv_try  = {dv_rem, dv_sh[WORD_W-1]};
    if (dv_try >= {1'b0, n}) begin
      dv_try = dv_try - {1'b0, n};
    end
    ex_lo_n = (exc_rd < n) ? ex_mid : ex_lo;
    ex_hi_n = (exc_rd < n) ? ex_hi : ex_mid;
    ex_sum  = {1'b0, ex_lo_n} + {1'b0, ex_hi_n};
    ex_mid_n = ex_sum[EA:1];
    stop = late ? pc_eff : early_eff;
  end

  // Modular multiplier hookup
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  always_comb begin
    mm_req.n     = n;
    mm_req.start = 1'b0;
    mm_req.a     = pw_b;
    mm_req.b     = pw_b;
    if (state == S_PW && pw_e != '0) begin
      mm_req.start = 1'b1;
      if (pw_e[0]) begin
        mm_req.a = pw_r;
      end
    end else if (state == S_PW_MR && mm_rsp.done) begin
      mm_req.start = 1'b1;
    end
  end

  pt64_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.mode != MODE_TEST) begin
            state_next = S_FIN;
          end else if (in_ch.operand_word <= 64'd3 || !in_ch.operand_word[0]) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SQRT;
          end
        end
      end
      S_SQRT:   if (sq_bit == 64'd1) state_next = S_SQCHK;
      S_SQCHK:  state_next = (sq_rem == '0) ? S_FIN : S_TD_RD;
      S_TD_RD: begin
        if (idx >= stop) begin
          if (!late) begin
            state_next = S_DIV;
          end else if (ec_eff == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_EX_R0;
          end
        end else begin
          state_next = S_TD_M0;
        end
      end
      S_TD_M0:  state_next = (rd_prime > pmax) ? S_FIN : S_TD_M1;
      S_TD_M1:  state_next = S_TD_M2;
      S_TD_M2:  state_next = S_TD_CMP;
      S_TD_CMP: state_next = (acc <= rd_quot) ? S_FIN : S_TD_RD;
      S_DIV:    if (k == 6'd63) state_next = S_PW;
      S_PW: begin
        if (pw_e == '0) begin
          state_next = S_PW_CHK;
        end else begin
          state_next = pw_e[0] ? S_PW_MR : S_PW_MB;
        end
      end
      S_PW_MR:  if (mm_rsp.done) state_next = S_PW_MB;
      S_PW_MB:  if (mm_rsp.done) state_next = S_PW;
      S_PW_CHK: state_next = (pw_r != 64'd1 && pw_r != n - 64'd1) ? S_FIN : S_TD_RD;
      S_EX_R0:  state_next = S_EX_RH;
      S_EX_RH:  state_next = S_EX_C1;
      S_EX_C1: begin
        if (ex_lt0 || n > exc_rd || ex_eq0 || exc_rd == n) begin
          state_next = S_FIN;
        end else begin
          state_next = S_EX_RM;
        end
      end
      S_EX_RM:  state_next = S_EX_CM;
      S_EX_CM: begin
        if (exc_rd == n || ex_mid_n == ex_lo_n) begin
          state_next = S_FIN;
        end else begin
          state_next = S_EX_RM;
        end
      end
      S_FIN:    if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Midpoint of two table indexes
  function automatic logic [EA-1:0] ex_sum_c1(input logic [EA-1:0] lo,
                                              input logic [EA-1:0] hi);
    logic [EA:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[EA:1];
  endfunction

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n       <= in_ch.operand_word;
        sq_rem  <= in_ch.operand_word;
        sq_root <= '0;
        sq_bit  <= 64'h4000_0000_0000_0000;
        idx     <= '0;
        late    <= 1'b0;
        if (in_ch.mode != MODE_TEST) begin
          cause <= CAUSE_LOAD;
        end else if (in_ch.operand_word <= 64'd1) begin
          cause <= CAUSE_TRIVIAL;
        end else if (in_ch.operand_word <= 64'd3) begin
          cause <= CAUSE_SMALL;
        end else begin
          cause <= CAUSE_TRIVIAL;
        end
      end
      S_SQRT: begin
        if (sq_rem >= sq_try) begin
          sq_rem  <= sq_rem - sq_try;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_SQCHK: begin
        pmax  <= sq_root[PRIME_W-1:0];
        cause <= CAUSE_SQUARE;
      end
      S_TD_RD: begin
        dv_rem <= '0;
        dv_sh  <= witness_base;
        k      <= '0;
        ex_lo  <= '0;
        ex_hi  <= EA'(ec_eff - EW'(1));
        cause  <= CAUSE_PASSED;
      end
      S_TD_M0: begin
        acc   <= prod;
        cause <= CAUSE_BOUND;
      end
      S_TD_M1:  acc[63:32] <= acc[63:32] + prod[31:0];
      S_TD_M2:  acc[63:32] <= acc[63:32] + prod[31:0];
      S_TD_CMP: begin
        cause <= CAUSE_DIVISOR;
        idx   <= idx + IW'(1);
      end
      S_DIV: begin
        dv_rem <= dv_try[WORD_W-1:0];
        dv_sh  <= {dv_sh[WORD_W-2:0], 1'b0};
        k      <= k + 6'd1;
        pw_r   <= 64'd1;
        pw_b   <= dv_try[WORD_W-1:0];
        pw_e   <= n >> 1;
      end
      S_PW_MR:  if (mm_rsp.done) pw_r <= mm_rsp.res;
      S_PW_MB: begin
        if (mm_rsp.done) begin
          pw_b <= mm_rsp.res;
          pw_e <= pw_e >> 1;
        end
      end
      S_PW_CHK: begin
        cause <= CAUSE_EULER;
        late  <= 1'b1;
      end
      S_EX_RH: begin
        ex_lt0 <= n < exc_rd;
        ex_eq0 <= exc_rd == n;
      end
      S_EX_C1: begin
        ex_mid <= ex_sum_c1(ex_lo, ex_hi);
        cause  <= (ex_lt0 || n > exc_rd) ? CAUSE_PASSED : CAUSE_EXCEPTION;
      end
      S_EX_CM: begin
        ex_lo  <= ex_lo_n;
        ex_hi  <= ex_hi_n;
        ex_mid <= ex_mid_n;
        cause  <= (exc_rd == n) ? CAUSE_EXCEPTION : CAUSE_PASSED;
      end
      S_FIN: begin
        if (!out_valid || out_ch.ready) begin
          out_prime <= (cause == CAUSE_SMALL || cause == CAUSE_BOUND ||
                        cause == CAUSE_PASSED);
          out_cause <= cause;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.is_prime      = out_prime;
  assign out_ch.verdict_cause = out_cause;

endmodule

>>> tb/primality_test_64bit_tb.sv
// Self-checking testbench of primality_test_64bit: directed table, then random phases.
// Depends on pt64_pkg, pt64_in_if and pt64_out_if; predicts untyped verdicts in-house.
module primality_test_64bit_tb;
  import pt64_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] quo;
  } item_t;

  typedef struct {
    logic               prime;
    logic [CAUSE_W-1:0] cause;
  } verdict_t;

  // Directed row: fill computes inverse and quotient, typed gives the verdict
  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  op;
    bit                 fill;
    bit                 typed;
    logic [CAUSE_W-1:0] cause;
  } row_t;

  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 200000;
  // Low table slots that are loaded before the random phases
  localparam int PRIME_FILL = 24;
  localparam int EXC_FILL = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WITNESS;
  logic [WORD_W-1:0] cfg_wdata = '0;

  pt64_in_if in_ch ();
  pt64_out_if out_ch ();

  primality_test_64bit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of tables and registers
  logic [PRIME_W-1:0] sh_prime [DEPTH];
  logic [WORD_W-1:0]  sh_inv [DEPTH];
  logic [WORD_W-1:0]  sh_quo [DEPTH];
  logic [WORD_W-1:0]  sh_exc [DEPTH];
  logic [WORD_W-1:0]  sh_witness;
  logic [COUNT_W-1:0] sh_pcount;
  logic [COUNT_W-1:0] sh_ecount;

  logic [PRIME_W-1:0] odd_primes [DEPTH];
  verdict_t pending_verdicts [$];
  int errors = 0;
  int tests_sent = 0;
  int loads_sent = 0;
  int verdicts_seen = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  int cause_hits [9];

  function automatic logic [WORD_W-1:0] mod_mul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                                logic [WORD_W-1:0] n);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return WORD_W'(prod % {64'd0, n});
  endfunction

  function automatic logic [WORD_W-1:0] mod_pow(logic [WORD_W-1:0] w, logic [WORD_W-1:0] e,
                                                logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] base;
    acc = 1;
    base = w % n;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, base, n);
      base = mod_mul(base, base, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] int_sqrt(logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] root;
    logic [WORD_W-1:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Scan divisors [idx, stop); CAUSE_LOAD means no verdict yet
  function automatic logic [CAUSE_W-1:0] scan_divisors(logic [WORD_W-1:0] n,
      logic [WORD_W-1:0] pmax, inout int idx, input int stop);
    logic [WORD_W-1:0] prod;
    for (; idx < stop; idx++) begin
      if (WORD_W'(sh_prime[idx]) > pmax) return CAUSE_BOUND;
      prod = sh_inv[idx] * n;
      if (prod <= sh_quo[idx]) return CAUSE_DIVISOR;
    end
    return CAUSE_LOAD;
  endfunction

  // Fixed bisection over the exception list
  function automatic bit listed_exception(logic [WORD_W-1:0] n, int count);
    int lo;
    int hi;
    int mid;
    if (count == 0) return 1'b0;
    lo = 0;
    hi = count - 1;
    if (n < sh_exc[lo] || n > sh_exc[hi]) return 1'b0;
    if (sh_exc[lo] == n || sh_exc[hi] == n) return 1'b1;
    mid = (lo + hi) / 2;
    forever begin
      if (sh_exc[mid] == n) return 1'b1;
      if (sh_exc[mid] < n) lo = mid;
      else hi = mid;
      mid = (lo + hi) / 2;
      if (mid == lo) return 1'b0;
    end
  endfunction

  function automatic logic [CAUSE_W-1:0] candidate_cause(logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] pmax;
    logic [WORD_W-1:0] pw;
    logic [CAUSE_W-1:0] c;
    int idx;
    int pc;
    int ec;
    int early;
    idx = 0;
    if (n <= 1) return CAUSE_TRIVIAL;
    if (n <= 3) return CAUSE_SMALL;
    if (!n[0]) return CAUSE_TRIVIAL;
    pmax = int_sqrt(n);
    if (pmax * pmax == n) return CAUSE_SQUARE;
    pc = (sh_pcount > DEPTH) ? DEPTH : int'(sh_pcount);
    ec = (sh_ecount > DEPTH) ? DEPTH : int'(sh_ecount);
    early = (pc < EARLY_PRIMES_DEF) ? pc : EARLY_PRIMES_DEF;
    c = scan_divisors(n, pmax, idx, early);
    if (c != CAUSE_LOAD) return c;
    pw = mod_pow(sh_witness, (n - 1) >> 1, n);
    if (pw != 1 && pw != n - 1) return CAUSE_EULER;
    c = scan_divisors(n, pmax, idx, pc);
    if (c != CAUSE_LOAD) return c;
    if (listed_exception(n, ec)) return CAUSE_EXCEPTION;
    return CAUSE_PASSED;
  endfunction

  // Advance the shadow state by one item and return its verdict
  function automatic verdict_t apply_item(item_t it);
    verdict_t v;
    v.cause = CAUSE_LOAD;
    case (it.mode)
      MODE_TEST: v.cause = candidate_cause(it.op);
      MODE_LOAD_PRIME: begin
        sh_prime[it.slot] = it.op[PRIME_W-1:0];
        sh_inv[it.slot] = it.inv;
        sh_quo[it.slot] = it.quo;
      end
      MODE_LOAD_EXC: sh_exc[it.slot] = it.op;
      default: ;
    endcase
    v.prime = (v.cause == CAUSE_SMALL || v.cause == CAUSE_BOUND || v.cause == CAUSE_PASSED);
    return v;
  endfunction

  function automatic item_t prime_entry(int k, logic [SLOT_W-1:0] slot);
    item_t it;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] x;
    p = WORD_W'(odd_primes[k]);
    x = p;
    repeat (6) x = x * (64'd2 - p * x);
    it.mode = MODE_LOAD_PRIME;
    it.slot = slot;
    it.op = p;
    it.inv = x;
    it.quo = {WORD_W{1'b1}} / p;
    return it;
  endfunction

  function automatic item_t test_item(logic [WORD_W-1:0] n);
    item_t it;
    it.mode = MODE_TEST;
    it.slot = SLOT_W'($urandom);
    it.op = n;
    it.inv = {$urandom, $urandom};
    it.quo = {$urandom, $urandom};
    return it;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 8);
  endfunction

  // Drive one item, hold it until the transfer, then queue its verdict
  task automatic send_item(item_t it, bit typed = 1'b0, logic [CAUSE_W-1:0] cause = CAUSE_LOAD);
    int gap;
    verdict_t v;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.table_slot <= it.slot;
    in_ch.operand_word <= it.op;
    in_ch.inverse_word <= it.inv;
    in_ch.quotient_word <= it.quo;
    do @(posedge clk); while (!in_ch.ready);
    v = apply_item(it);
    if (typed) begin
      v.cause = cause;
      v.prime = (cause == CAUSE_SMALL || cause == CAUSE_BOUND || cause == CAUSE_PASSED);
    end
    pending_verdicts.push_back(v);
    if (it.mode == MODE_TEST) tests_sent++;
    else loads_sent++;
  endtask

  // Drain, then write registers while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WITNESS: sh_witness = value;
      CFG_PRIME_CNT: sh_pcount = value[COUNT_W-1:0];
      CFG_EXC_CNT: sh_ecount = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic random_item();
    int pick;
    int k;
    int j;
    logic [WORD_W-1:0] n;
    item_t it;
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2: n = WORD_W'($urandom_range(5, 65535)) | 64'd1;
        3: begin
          j = $urandom_range(0, 300);
          n = WORD_W'(odd_primes[j]) * WORD_W'(odd_primes[$urandom_range(0, DEPTH - 1)]);
        end
        4: n = {32'd0, $urandom} | 64'd1;
        5: n = sh_exc[$urandom_range(0, EXC_FILL - 1)];
        6: begin
          n = WORD_W'($urandom_range(3, 65535)) | 64'd1;
          n = n * n;
        end
        7: n = {$urandom, $urandom};
        8: n = WORD_W'(odd_primes[$urandom_range(0, DEPTH - 1)]);
        default: n = ($urandom_range(0, 1) != 0) ? WORD_W'($urandom_range(0, 8))
                                                  : ({$urandom, $urandom} & ~64'd1);
      endcase
      it = test_item(n);
    end else if (pick < 17) begin
      it = prime_entry($urandom_range(0, DEPTH - 1), SLOT_W'($urandom));
    end else if (pick < 19) begin
      it = test_item({$urandom, $urandom});
      it.mode = MODE_LOAD_EXC;
    end else begin
      it = test_item({$urandom, $urandom});
      it.mode = 2'd3;
    end
    send_item(it);
  endtask

  // Receive verdicts with random stalls and compare to the oldest prediction
  initial begin
    verdict_t want;
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict prime=%0b cause=%0d", $time, out_ch.is_prime,
                 out_ch.verdict_cause);
      end else begin
        want = pending_verdicts.pop_front();
        if (want.cause <= CAUSE_PASSED) cause_hits[want.cause]++;
        if (out_ch.is_prime !== want.prime) begin
          errors++;
          $display("%0t: is_prime expected %0b actual %0b", $time, want.prime, out_ch.is_prime);
        end
        if (out_ch.verdict_cause !== want.cause) begin
          errors++;
          $display("%0t: verdict_cause expected %0d actual %0d", $time, want.cause,
                   out_ch.verdict_cause);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d verdicts pending", $time,
               pending_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    item_t it;
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] phase_w [6];
    logic [WORD_W-1:0] phase_pc [6];
    logic [WORD_W-1:0] phase_ec [6];
    int cnt;
    logic [PRIME_W-1:0] cand;
    bit is_p;

    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_TEST;
    in_ch.table_slot <= '0;
    in_ch.operand_word <= '0;
    in_ch.inverse_word <= '0;
    in_ch.quotient_word <= '0;
    sh_witness = 2;
    sh_pcount = 0;
    sh_ecount = 1;

    // Build the list of the first odd primes
    cnt = 0;
    cand = 3;
    while (cnt < DEPTH) begin
      is_p = 1'b1;
      for (int d = 3; d * d <= cand; d += 2)
        if (cand % d == 0) is_p = 1'b0;
      if (is_p) begin
        odd_primes[cnt] = cand;
        cnt++;
      end
      cand += 2;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: extremes, every mode and the special cases
    rows = '{
      '{MODE_LOAD_EXC, 10'd0, 64'd561, 1'b0, 1'b1, CAUSE_LOAD},
      '{MODE_LOAD_PRIME, 10'd0, 64'd0, 1'b1, 1'b1, CAUSE_LOAD},
      '{MODE_LOAD_PRIME, 10'd1, 64'd1, 1'b1, 1'b1, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'd0, 1'b0, 1'b1, CAUSE_TRIVIAL},
      '{MODE_TEST, 10'd0, 64'd1, 1'b0, 1'b1, CAUSE_TRIVIAL},
      '{MODE_TEST, 10'd0, 64'd2, 1'b0, 1'b1, CAUSE_SMALL},
      '{MODE_TEST, 10'd0, 64'd3, 1'b0, 1'b1, CAUSE_SMALL},
      '{MODE_TEST, 10'd0, 64'd4, 1'b0, 1'b1, CAUSE_TRIVIAL},
      '{MODE_TEST, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, CAUSE_TRIVIAL},
      '{MODE_TEST, 10'd0, 64'd9, 1'b0, 1'b1, CAUSE_SQUARE},
      '{MODE_TEST, 10'd0, 64'hFFFF_FFFE_0000_0001, 1'b0, 1'b1, CAUSE_SQUARE},
      '{2'd3, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, CAUSE_LOAD},
      '{MODE_LOAD_PRIME, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, CAUSE_LOAD},
      '{MODE_LOAD_EXC, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'd15, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'd561, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'd97, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'd341, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, CAUSE_LOAD},
      '{MODE_TEST, 10'd0, 64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 1'b0, CAUSE_LOAD}
    };
    foreach (rows[r]) begin
      if (rows[r].fill) it = prime_entry(int'(rows[r].op), rows[r].slot);
      else begin
        it = test_item(rows[r].op);
        it.mode = rows[r].mode;
        it.slot = rows[r].slot;
        if (rows[r].mode == MODE_LOAD_PRIME) begin
          it.inv = {WORD_W{1'b1}};
          it.quo = {WORD_W{1'b1}};
        end
      end
      send_item(it, rows[r].typed, rows[r].cause);
    end

    // Fill the low slots of both tables; the exception list ascends from
    // known pseudoprimes
    no_gaps = 1'b1;
    for (int k = 0; k < PRIME_FILL; k++) send_item(prime_entry(k, SLOT_W'(k)));
    seq = 64'd561;
    for (int k = 0; k < EXC_FILL; k++) begin
      it = test_item(seq);
      it.mode = MODE_LOAD_EXC;
      it.slot = SLOT_W'(k);
      send_item(it);
      case (k)
        0: seq = 64'd1105;
        1: seq = 64'd1729;
        2: seq = 64'd1905;
        3: seq = 64'd2047;
        4: seq = 64'd2465;
        default: seq = seq + ({32'd0, $urandom} << 21) + 64'd2;
      endcase
    end

    // Random phases over several register settings; counts stay within the
    // loaded slots
    phase_w = '{64'd2, {$urandom, $urandom}, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3,
                {$urandom, $urandom} | 64'd2};
    phase_pc = '{64'd24, 64'd12, 64'd5, 64'd0, 64'd1, 64'd20};
    phase_ec = '{64'd8, 64'd3, 64'd0, 64'd8, 64'd1, 64'd6};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_WITNESS, phase_w[p]);
      write_reg(CFG_PRIME_CNT, phase_pc[p]);
      write_reg(CFG_EXC_CNT, phase_ec[p]);
      no_gaps = (p == 2);
      repeat (8) random_item();
    end

    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d candidate tests and %0d loads, %0d verdicts checked.",
             tests_sent, loads_sent, verdicts_seen);
    $display("Verdicts by cause 1..8: %0d %0d %0d %0d %0d %0d %0d %0d", cause_hits[1],
             cause_hits[2], cause_hits[3], cause_hits[4], cause_hits[5], cause_hits[6],
             cause_hits[7], cause_hits[8]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
